/* rtl/rc4_pkg.sv */
// ============================================================================
// rc4_pkg
// Sizes, widths and sequencer states shared by the RC4 stream cipher engine.
// ============================================================================
`default_nettype none

package rc4_pkg;

   // Largest key that the key store holds; longer keys are truncated.
   localparam int KEY_MAX    = 256;
   localparam int TABLE_SIZE = 256;

   localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int KCNT_W = $clog2(KEY_MAX + 1);
   localparam int TAB_AW = $clog2(TABLE_SIZE);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_INIT   = 9'b000000010,
      ST_KS_RD  = 9'b000000100,
      ST_KS_ACC = 9'b000001000,
      ST_KS_SW  = 9'b000010000,
      ST_KS_W2  = 9'b000100000,
      ST_GEN_RI = 9'b001000000,
      ST_GEN_SW = 9'b010000000,
      ST_GEN_KS = 9'b100000000
   } state_type;

endpackage

`default_nettype wire

/* rtl/rc4_stream_cipher.sv */
// ============================================================================
// rc4_stream_cipher
// RC4 engine. The request channel carries key bytes (req_type low) and data
// bytes (req_type high); one transfer moves one byte. A key byte with
// req_last_key set ends the key and starts the key schedule (a table fill,
// then a swap step per entry), during which req_stall is high. Key bytes are
// otherwise taken one per cycle while the response slot is free, and give no
// response. A data byte gives one response transfer on rsp_byte_out: the
// byte XOR the keystream byte, registered after ST_GEN_RI, ST_GEN_SW and
// ST_GEN_KS (no request is taken in these), as the single read port of the
// permutation table reads S[i], S[j] and S[S[i]+S[j]] one after the other.
// Before any key is scheduled a data byte passes through unchanged in the
// cycle after its transfer. Reset clears the indices, the key count and the
// key-loaded flag; the table and key store stay unknown until written. A
// result waits in the response register while rsp_stall is high, and no
// further request is taken until that slot is free.
// ============================================================================
`default_nettype none

module rc4_stream_cipher (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic       req_type,
   input  wire logic [7:0] req_byte_in,
   input  wire logic       req_last_key,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_byte_out
);

   localparam logic [rc4_pkg::KCNT_W-1:0] KeyMaxCnt = rc4_pkg::KCNT_W'(rc4_pkg::KEY_MAX);

   // Sequencer and control registers.
   rc4_pkg::state_type state_ff, state_in;
   logic [rc4_pkg::KCNT_W-1:0] key_count_ff, key_count_in;
   logic [rc4_pkg::KCNT_W-1:0] key_len_ff, key_len_in;
   logic [rc4_pkg::KEY_AW-1:0] kidx_ff, kidx_in;
   logic [rc4_pkg::TAB_AW-1:0] n_ff, n_in;
   logic [7:0] acc_ff, acc_in;
   logic [7:0] i_ff, i_in;
   logic [7:0] j_ff, j_in;
   logic       key_ready_ff, key_ready_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [7:0] si_ff, si_in;
   logic [7:0] sj_ff, sj_in;
   logic [7:0] t_ff, t_in;
   logic [7:0] byte_ff, byte_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;

   // Permutation table and key store, each with one write and one read port.
   logic [7:0] perm_mem [rc4_pkg::TABLE_SIZE];
   logic [7:0] key_mem [rc4_pkg::KEY_MAX];
   logic [7:0] perm_rd_ff;
   logic [7:0] key_rd_ff;

   logic                       perm_we;
   logic [rc4_pkg::TAB_AW-1:0] perm_waddr;
   logic [7:0]                 perm_wdata;
   logic [rc4_pkg::TAB_AW-1:0] perm_raddr;
   logic                       key_we;
   logic [rc4_pkg::KEY_AW-1:0] key_waddr;

   // The shared byte adder for the key-schedule accumulator, j and t sums.
   logic [7:0] add_a, add_b, add_c, add_sum;

   logic                       slot_free;
   logic                       req_take;
   logic [7:0]                 ks_byte;
   logic [rc4_pkg::KCNT_W-1:0] kidx_step;
   logic [rc4_pkg::KCNT_W-1:0] count_next;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != rc4_pkg::ST_IDLE) || !slot_free;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_byte_out = rsp_byte_ff;

   assign add_sum = add_a + add_b + add_c;

   // Keystream byte with the two pending swap writes forwarded: on the first
   // cycle in ST_GEN_KS the read data predates both writes of the swap.
   always_comb begin
      if (t_ff == j_ff) begin
         ks_byte = si_ff;
      end else if (t_ff == i_ff) begin
         ks_byte = sj_ff;
      end else begin
         ks_byte = perm_rd_ff;
      end
   end

   assign kidx_step  = rc4_pkg::KCNT_W'(kidx_ff) + rc4_pkg::KCNT_W'(1);
   assign count_next = (key_count_ff < KeyMaxCnt) ? (key_count_ff + rc4_pkg::KCNT_W'(1))
                                                  : key_count_ff;

   always_comb begin
      state_in     = state_ff;
      key_count_in = key_count_ff;
      key_len_in   = key_len_ff;
      kidx_in      = kidx_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      key_ready_in = key_ready_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      si_in        = si_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      byte_in      = byte_ff;
      rsp_byte_in  = rsp_byte_ff;

      add_a = 8'd0;
      add_b = 8'd0;
      add_c = 8'd0;

      perm_we    = 1'b0;
      perm_waddr = n_ff;
      perm_wdata = perm_rd_ff;
      perm_raddr = i_ff + 8'd1;
      key_we     = 1'b0;
      key_waddr  = key_count_ff[rc4_pkg::KEY_AW-1:0];

      case (state_ff)
         rc4_pkg::ST_IDLE: begin
            // The table read of S[i+1] runs ahead so that a data byte finds
            // it ready in the next cycle.
            if (req_take) begin
               if (!req_type) begin
                  key_we       = (key_count_ff < KeyMaxCnt);
                  key_count_in = count_next;
                  if (req_last_key) begin
                     key_len_in   = count_next;
                     key_count_in = '0;
                     n_in         = '0;
                     state_in     = rc4_pkg::ST_INIT;
                  end
               end else if (!key_ready_ff) begin
                  rsp_byte_in  = req_byte_in;
                  rsp_valid_in = 1'b1;
               end else begin
                  i_in     = i_ff + 8'd1;
                  byte_in  = req_byte_in;
                  state_in = rc4_pkg::ST_GEN_RI;
               end
            end
         end
         rc4_pkg::ST_INIT: begin
            perm_we    = 1'b1;
            perm_waddr = n_ff;
            perm_wdata = 8'(n_ff);
            n_in       = n_ff + 1'b1;
            if (n_ff == '1) begin
               acc_in   = 8'd0;
               kidx_in  = '0;
               state_in = rc4_pkg::ST_KS_RD;
            end
         end
         rc4_pkg::ST_KS_RD: begin
            perm_raddr = n_ff;
            state_in   = rc4_pkg::ST_KS_ACC;
         end
         rc4_pkg::ST_KS_ACC: begin
            add_a      = acc_ff;
            add_b      = perm_rd_ff;
            add_c      = key_rd_ff;
            acc_in     = add_sum;
            si_in      = perm_rd_ff;
            perm_raddr = add_sum;
            state_in   = rc4_pkg::ST_KS_SW;
         end
         rc4_pkg::ST_KS_SW: begin
            perm_we    = 1'b1;
            perm_waddr = n_ff;
            perm_wdata = perm_rd_ff;
            state_in   = rc4_pkg::ST_KS_W2;
         end
         rc4_pkg::ST_KS_W2: begin
            perm_we    = 1'b1;
            perm_waddr = acc_ff;
            perm_wdata = si_ff;
            n_in       = n_ff + 1'b1;
            kidx_in    = (kidx_step == key_len_ff) ? '0 : kidx_step[rc4_pkg::KEY_AW-1:0];
            if (n_ff == '1) begin
               i_in         = 8'd0;
               j_in         = 8'd0;
               key_ready_in = 1'b1;
               state_in     = rc4_pkg::ST_IDLE;
            end else begin
               state_in = rc4_pkg::ST_KS_RD;
            end
         end
         rc4_pkg::ST_GEN_RI: begin
            add_a      = j_ff;
            add_b      = perm_rd_ff;
            j_in       = add_sum;
            si_in      = perm_rd_ff;
            perm_raddr = add_sum;
            state_in   = rc4_pkg::ST_GEN_SW;
         end
         rc4_pkg::ST_GEN_SW: begin
            add_a      = si_ff;
            add_b      = perm_rd_ff;
            sj_in      = perm_rd_ff;
            t_in       = add_sum;
            perm_raddr = add_sum;
            perm_we    = 1'b1;
            perm_waddr = i_ff;
            perm_wdata = perm_rd_ff;
            state_in   = rc4_pkg::ST_GEN_KS;
         end
         rc4_pkg::ST_GEN_KS: begin
            // Writing S[j] again while waiting on the response slot is harmless.
            perm_raddr = t_ff;
            perm_we    = 1'b1;
            perm_waddr = j_ff;
            perm_wdata = si_ff;
            if (slot_free) begin
               rsp_byte_in  = byte_ff ^ ks_byte;
               rsp_valid_in = 1'b1;
               state_in     = rc4_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rc4_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_waddr] <= perm_wdata;
      end
      perm_rd_ff <= perm_mem[perm_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= req_byte_in;
      end
      key_rd_ff <= key_mem[kidx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rc4_pkg::ST_IDLE;
         key_count_ff <= '0;
         key_len_ff   <= rc4_pkg::KCNT_W'(1);
         kidx_ff      <= '0;
         n_ff         <= '0;
         acc_ff       <= 8'd0;
         i_ff         <= 8'd0;
         j_ff         <= 8'd0;
         key_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         key_count_ff <= key_count_in;
         key_len_ff   <= key_len_in;
         kidx_ff      <= kidx_in;
         n_ff         <= n_in;
         acc_ff       <= acc_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         key_ready_ff <= key_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      t_ff        <= t_in;
      byte_ff     <= byte_in;
      rsp_byte_ff <= rsp_byte_in;
   end

`ifndef SYNTHESIS
   // The key length in use is never zero and never beyond the key store.
   a_key_len_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != rc4_pkg::ST_IDLE) |->
         (key_len_ff != '0) && (key_len_ff <= KeyMaxCnt))
      else $error("key length out of range during key schedule");

   // The key index wraps before reaching the key length.
   a_kidx_below_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rc4_pkg::ST_KS_RD) |->
         (rc4_pkg::KCNT_W'(kidx_ff) < key_len_ff))
      else $error("key index beyond key length");

   // The last swap step leaves a loaded key with both indices cleared.
   a_sched_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rc4_pkg::ST_KS_W2 && n_ff == '1) |=>
         (state_ff == rc4_pkg::ST_IDLE && key_ready_ff && i_ff == 8'd0 && j_ff == 8'd0))
      else $error("key schedule did not finish cleanly");

   // A keyed data transfer starts the generator in the next cycle.
   a_gen_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_type && key_ready_ff) |=>
         (state_ff == rc4_pkg::ST_GEN_RI))
      else $error("data transfer did not start the generator");
`endif

endmodule

`default_nettype wire
